[src/rhcc_pkg.sv]
// rhcc_pkg: shared types and constants for the rgb565 hsl color classifier
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rhcc_pkg;

  // field widths
  localparam int PIX_W      = 16;
  localparam int CH_W       = 8;
  localparam int SUM_W      = 9;
  localparam int HUE_NUM_W  = 14;
  localparam int SAT_NUM_W  = 16;
  localparam int Q_W        = 8;
  localparam int CFG_IDX_W  = 3;

  // scale constants
  localparam logic [7:0]  SCALE_MAX = 8'd240;
  localparam logic [7:0]  HUE_STEP  = 8'd40;
  localparam logic [7:0]  HUE_GREEN = 8'd80;
  localparam logic [7:0]  HUE_BLUE  = 8'd160;
  localparam logic [7:0]  LUM_HALF  = 8'd120;
  localparam logic [8:0]  SAT_SPAN  = 9'd480;
  // x*16/17 done as multiply by floor(65535/17) then one correction
  localparam logic [12:0] LUM_DIV   = 13'd17;
  localparam logic [11:0] LUM_RECIP = 12'd3855;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LUM_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LUM_HIGH = 3'd5;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  typedef struct packed {
    logic [7:0] hue_low;
    logic [7:0] hue_high;
    logic [7:0] sat_low;
    logic [7:0] sat_high;
    logic [7:0] lum_low;
    logic [7:0] lum_high;
  } cfg_t;

  // flags and values that ride alongside the dividers
  typedef struct packed {
    logic       grey;
    logic       neg;
    max_sel_t   sel;
    logic       sat_zero;
    logic       sat_ovf;
    logic [7:0] lum;
  } side_t;

  typedef struct packed {
    logic [HUE_NUM_W-1:0] hue_num;
    logic [CH_W-1:0]      hue_den;
    logic [SAT_NUM_W-1:0] sat_num;
    logic [SUM_W-1:0]     sat_den;
    side_t                side;
  } div_in_t;

  typedef struct packed {
    logic [HUE_NUM_W-1:0] h_rem;
    logic [CH_W-1:0]      h_den;
    logic [Q_W-1:0]       h_q;
    logic [SAT_NUM_W-1:0] s_rem;
    logic [SUM_W-1:0]     s_den;
    logic [Q_W-1:0]       s_q;
    side_t                side;
  } div_stage_t;

  typedef struct packed {
    logic [Q_W-1:0] hue_q;
    logic [Q_W-1:0] sat_q;
    side_t          side;
  } div_out_t;

endpackage

`default_nettype wire

[src/rhcc_front.sv]
// rhcc_front: byte swap, channel expansion, max/min, luminance and divider operands
// five register stages; uses rhcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rhcc_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [rhcc_pkg::PIX_W-1:0]  pixel_word,
  output logic                             out_valid,
  output rhcc_pkg::div_in_t                out_word
);
  import rhcc_pkg::*;

  // stage 1: swapped and expanded channels
  logic [PIX_W-1:0] swapped;
  logic             v1;
  logic [CH_W-1:0]  r1, g1, b1;

  // stage 2: extremes and hue difference
  logic [CH_W-1:0]  mx, mn, mag;
  logic [CH_W:0]    dif;
  max_sel_t         sel;
  logic             v2, neg2;
  logic [CH_W-1:0]  d2, mag2;
  logic [SUM_W-1:0] sum2;
  max_sel_t         sel2;

  // stage 3: numerators and reciprocal product
  logic [24:0]          prod;
  logic                 v3, neg3, grey3;
  logic [HUE_NUM_W-1:0] hue_num3;
  logic [SAT_NUM_W-1:0] sat_num3;
  logic [SUM_W-1:0]     q03, sum3;
  logic [CH_W-1:0]      d3;
  max_sel_t             sel3;

  // stage 4: luminance
  logic [12:0]          m17, lrem;
  logic [SUM_W-1:0]     lq;
  logic                 v4, neg4, grey4;
  logic [7:0]           lum4;
  logic [HUE_NUM_W-1:0] hue_num4;
  logic [SAT_NUM_W-1:0] sat_num4;
  logic [SUM_W-1:0]     sum4;
  logic [CH_W-1:0]      d4;
  max_sel_t             sel4;

  // stage 5: saturation divisor
  logic [SUM_W-1:0] sden;
  logic             szero, sovf;

  assign swapped = {pixel_word[7:0], pixel_word[15:8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    r1 <= {swapped[15:11], 3'b000};
    g1 <= {swapped[10:5], 2'b00};
    b1 <= {swapped[4:0], 3'b000};
  end

  always_comb begin
    mx = r1;
    if (g1 > mx) mx = g1;
    if (b1 > mx) mx = b1;
    mn = r1;
    if (g1 < mn) mn = g1;
    if (b1 < mn) mn = b1;
    // ties go to red, then green
    priority if (mx == r1) begin
      sel = MAX_RED;
    end else if (mx == g1) begin
      sel = MAX_GREEN;
    end else begin
      sel = MAX_BLUE;
    end
    unique case (sel)
      MAX_RED:   dif = {1'b0, g1} - {1'b0, b1};
      MAX_GREEN: dif = {1'b0, b1} - {1'b0, r1};
      MAX_BLUE:  dif = {1'b0, r1} - {1'b0, g1};
      default:   dif = '0;
    endcase
    mag = dif[CH_W] ? CH_W'(-dif) : dif[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    d2   <= mx - mn;
    sum2 <= {1'b0, mx} + {1'b0, mn};
    mag2 <= mag;
    neg2 <= dif[CH_W];
    sel2 <= sel;
  end

  assign prod = 25'({sum2, 4'b0000}) * 25'(LUM_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    // 40x as shift and add, 240x as shift and subtract
    hue_num3 <= (HUE_NUM_W'(mag2) << 5) + (HUE_NUM_W'(mag2) << 3);
    sat_num3 <= (SAT_NUM_W'(d2) << 8) - (SAT_NUM_W'(d2) << 4);
    q03      <= prod[24:16];
    sum3     <= sum2;
    d3       <= d2;
    grey3    <= (d2 == '0);
    neg3     <= neg2;
    sel3     <= sel2;
  end

  always_comb begin
    m17  = {q03, 4'b0000} + 13'(q03);
    lrem = {sum3, 4'b0000} - m17;
    lq   = (lrem >= LUM_DIV) ? q03 + 9'd1 : q03;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    lum4     <= lq[8:1];
    hue_num4 <= hue_num3;
    sat_num4 <= sat_num3;
    sum4     <= sum3;
    d4       <= d3;
    grey4    <= grey3;
    neg4     <= neg3;
    sel4     <= sel3;
  end

  always_comb begin
    szero = 1'b0;
    sden  = '0;
    priority if (grey4 || lum4 == '0) begin
      szero = 1'b1;
    end else if (lum4 <= LUM_HALF) begin
      sden = sum4;
    end else if (sum4 >= SAT_SPAN) begin
      szero = 1'b1;
    end else begin
      sden = SAT_SPAN - sum4;
    end
    // quotient would not fit in eight bits, so it clamps anyway
    sovf = {1'b0, sat_num4} >= {sden, 8'h00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4;
    end
    out_word.hue_num       <= hue_num4;
    out_word.hue_den       <= d4;
    out_word.sat_num       <= sat_num4;
    out_word.sat_den       <= sden;
    out_word.side.grey     <= grey4;
    out_word.side.neg      <= neg4;
    out_word.side.sel      <= sel4;
    out_word.side.sat_zero <= szero;
    out_word.side.sat_ovf  <= sovf;
    out_word.side.lum      <= lum4;
  end

endmodule

`default_nettype wire

[src/rhcc_div.sv]
// rhcc_div: two restoring dividers side by side, one quotient bit per stage
// hue and saturation lanes share the stage registers; uses rhcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rhcc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire rhcc_pkg::div_in_t in_word,
  output logic                   out_valid,
  output rhcc_pkg::div_out_t     out_word
);
  import rhcc_pkg::*;

  localparam int HT_W = CH_W + Q_W;
  localparam int ST_W = SUM_W + Q_W;

  div_stage_t       cur  [0:Q_W-1];
  div_stage_t       nxt  [0:Q_W-1];
  div_stage_t       pipe [0:Q_W-1];
  logic             vld  [0:Q_W-1];
  logic [HT_W-1:0]  h_trial [0:Q_W-1];
  logic [ST_W-1:0]  s_trial [0:Q_W-1];
  logic             h_take  [0:Q_W-1];
  logic             s_take  [0:Q_W-1];

  always_comb begin
    cur[0].h_rem = in_word.hue_num;
    cur[0].h_den = in_word.hue_den;
    cur[0].h_q   = '0;
    cur[0].s_rem = in_word.sat_num;
    cur[0].s_den = in_word.sat_den;
    cur[0].s_q   = '0;
    cur[0].side  = in_word.side;
    for (int s = 1; s < Q_W; s++) begin
      cur[s] = pipe[s-1];
    end
    // stage s decides quotient bit Q_W-1-s
    for (int s = 0; s < Q_W; s++) begin
      h_trial[s] = HT_W'(cur[s].h_den) << (Q_W - 1 - s);
      s_trial[s] = ST_W'(cur[s].s_den) << (Q_W - 1 - s);
      h_take[s]  = HT_W'(cur[s].h_rem) >= h_trial[s];
      s_take[s]  = ST_W'(cur[s].s_rem) >= s_trial[s];
      nxt[s]       = cur[s];
      nxt[s].h_rem = h_take[s] ? cur[s].h_rem - h_trial[s][HUE_NUM_W-1:0] : cur[s].h_rem;
      nxt[s].s_rem = s_take[s] ? cur[s].s_rem - s_trial[s][SAT_NUM_W-1:0] : cur[s].s_rem;
      nxt[s].h_q   = cur[s].h_q | (Q_W'(h_take[s]) << (Q_W - 1 - s));
      nxt[s].s_q   = cur[s].s_q | (Q_W'(s_take[s]) << (Q_W - 1 - s));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < Q_W; s++) begin
        vld[s] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int s = 1; s < Q_W; s++) begin
        vld[s] <= vld[s-1];
      end
    end
    for (int s = 0; s < Q_W; s++) begin
      pipe[s] <= nxt[s];
    end
  end

  assign out_valid      = vld[Q_W-1];
  assign out_word.hue_q = pipe[Q_W-1].h_q;
  assign out_word.sat_q = pipe[Q_W-1].s_q;
  assign out_word.side  = pipe[Q_W-1].side;

endmodule

`default_nettype wire

[src/rhcc_back.sv]
// rhcc_back: hue offset and sign, saturation clamp, window compare, result registers
// two register stages; uses rhcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rhcc_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire rhcc_pkg::div_out_t in_word,
  input  wire rhcc_pkg::cfg_t     cfg,
  output logic                    done,
  output logic [7:0]              hue,
  output logic [7:0]              saturation,
  output logic [7:0]              luminance,
  output logic                    is_match
);
  import rhcc_pkg::*;

  logic [7:0] h, s;
  logic       v1;
  logic [7:0] hue_r, sat_r, lum_r;
  logic       hit;

  always_comb begin
    logic [7:0] q;
    q = in_word.hue_q;
    priority if (in_word.side.grey) begin
      h = '0;
    end else begin
      unique case (in_word.side.sel)
        MAX_RED:   h = in_word.side.neg ? SCALE_MAX - q : q;
        MAX_GREEN: h = in_word.side.neg ? HUE_GREEN - q : HUE_GREEN + q;
        MAX_BLUE:  h = in_word.side.neg ? HUE_BLUE - q : HUE_BLUE + q;
        default:   h = '0;
      endcase
    end
    priority if (in_word.side.sat_zero) begin
      s = '0;
    end else if (in_word.side.sat_ovf || in_word.sat_q > SCALE_MAX) begin
      s = SCALE_MAX;
    end else begin
      s = in_word.sat_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    hue_r <= h;
    sat_r <= s;
    lum_r <= (in_word.side.lum > SCALE_MAX) ? SCALE_MAX : in_word.side.lum;
  end

  assign hit = hue_r >= cfg.hue_low && hue_r <= cfg.hue_high &&
               sat_r >= cfg.sat_low && sat_r <= cfg.sat_high &&
               lum_r >= cfg.lum_low && lum_r <= cfg.lum_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    hue        <= hue_r;
    saturation <= sat_r;
    luminance  <= lum_r;
    is_match   <= hit;
  end

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> hue <= SCALE_MAX && saturation <= SCALE_MAX && luminance <= SCALE_MAX)
    else $error("result outside 0..240");

  // |diff| never exceeds max-min, so the hue quotient stays within one sector
  a_hue_q: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_word.side.grey |-> in_word.hue_q <= HUE_STEP)
    else $error("hue quotient above sector width");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_word.side.grey |=> hue_r == '0 && sat_r == '0)
    else $error("grey pixel with nonzero hue or saturation");

  a_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid, 2))
    else $error("result strobe without divider word");

endmodule

`default_nettype wire

[src/rgb565_hsl_color_classifier.sv]
// rgb565_hsl_color_classifier: top level, config registers and the pixel pipeline
// instantiates rhcc_front, rhcc_div, rhcc_back; uses rhcc_pkg
//
//   channel   signals                               handshake
//   pixel     start, busy, pixel_word               start && !busy
//   result    done, hue, saturation, luminance,     done strobe, one cycle
//             is_match
//   config    cfg_valid, cfg_ready, cfg_index,      cfg_valid && cfg_ready
//             cfg_data
//
// one pixel per clock; busy stays low, every cycle may carry a new word
// a result strobes once its pixel has passed 5 front stages,
// 8 divider stages (one quotient bit each) and 2 back stages
// rst (synchronous) empties the pipeline and loads the default windows
// results cannot be held off; nothing in the pipeline ever stalls
`timescale 1ns / 1ps
`default_nettype none

module rgb565_hsl_color_classifier (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [rhcc_pkg::PIX_W-1:0]         pixel_word,
  output logic                                    done,
  output logic [7:0]                              hue,
  output logic [7:0]                              saturation,
  output logic [7:0]                              luminance,
  output logic                                    is_match,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rhcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [7:0]                         cfg_data
);
  import rhcc_pkg::*;

  cfg_t     cfg;
  logic     f_valid, d_valid;
  div_in_t  f_word;
  div_out_t d_word;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue_low  <= 8'd0;
      cfg.hue_high <= 8'd60;
      cfg.sat_low  <= 8'd190;
      cfg.sat_high <= 8'd240;
      cfg.lum_low  <= 8'd32;
      cfg.lum_high <= 8'd132;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HUE_LOW:  cfg.hue_low  <= cfg_data;
        REG_HUE_HIGH: cfg.hue_high <= cfg_data;
        REG_SAT_LOW:  cfg.sat_low  <= cfg_data;
        REG_SAT_HIGH: cfg.sat_high <= cfg_data;
        REG_LUM_LOW:  cfg.lum_low  <= cfg_data;
        REG_LUM_HIGH: cfg.lum_high <= cfg_data;
        default: ;
      endcase
    end
  end

  rhcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .pixel_word (pixel_word),
    .out_valid  (f_valid),
    .out_word   (f_word)
  );

  rhcc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_word   (f_word),
    .out_valid (d_valid),
    .out_word  (d_word)
  );

  rhcc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (d_valid),
    .in_word    (d_word),
    .cfg        (cfg),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .luminance  (luminance),
    .is_match   (is_match)
  );

endmodule

`default_nettype wire
